// File: sv/phc_pkg.sv
// Shared types, codes and constants for the pairing handshake controller.
`timescale 1ns / 1ps
package phc_pkg;

   localparam int PUBLIC_LEN     = 32;
   localparam int NONCE_LEN      = 8;
   localparam int CONFIRM_LEN    = 16;
   localparam int HDR_LEN        = 9;
   localparam int DEFAULT_WINDOW = 30000;
   localparam int QUEUE_DEPTH    = 2;

   localparam int OFFER_MIN   = HDR_LEN + PUBLIC_LEN + NONCE_LEN;
   localparam int CONFIRM_MIN = HDR_LEN + CONFIRM_LEN;

   typedef enum logic [2:0] {
      REQ_BEGIN   = 3'd0,
      REQ_OFFER   = 3'd1,
      REQ_CONFIRM = 3'd2,
      REQ_ABORT   = 3'd3,
      REQ_TICK    = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_WAITING    = 3'd1,
      ST_CONFIRMING = 3'd2,
      ST_DONE       = 3'd3,
      ST_ABORTED    = 3'd4
   } hs_state_type;

   typedef enum logic [2:0] {
      WHY_NONE        = 3'd0,
      WHY_THIRD       = 3'd1,
      WHY_TIMEOUT     = 3'd2,
      WHY_BAD_CONFIRM = 3'd3,
      WHY_BAD_KEY     = 3'd4,
      WHY_PEER        = 3'd5
   } why_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_BEGIN,
      OP_OFFER,
      OP_CONFIRM,
      OP_ABORT,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic [15:0] window;
      logic        hdr_ok;
      logic        offer_ok;
      logic        confirm_ok;
      logic        from_self;
      logic [63:0] sender_id;
      logic        key_ok;
      logic        tag_match;
   } cmd_type;

   typedef struct packed {
      hs_state_type new_state;
      why_type      abort_code;
      logic         tx_offer;
      logic         tx_confirm;
      logic         tx_abort;
      logic         completed;
      logic         aborted;
      logic         peer_accepted;
   } rsp_type;

endpackage

// File: sv/phc_front.sv
// Front stage: takes request transfers, classifies them and registers the command.
`timescale 1ns / 1ps
module phc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_type,
   input  logic [31:0]      req_now_ms,
   input  logic [15:0]      req_window_len,
   input  logic [7:0]       req_msg_len,
   input  logic [63:0]      req_sender_id,
   input  logic             req_key_ok,
   input  logic             req_tag_match,
   input  logic [63:0]      own_id,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output phc_pkg::cmd_type cmd
);
   import phc_pkg::*;

   cmd_type cmd_in;
   cmd_type cmd_ff;
   logic    valid_ff;
   logic    has_len;

   always_comb begin
      has_len = (req_msg_len != 8'd0);
      cmd_in            = '0;
      cmd_in.now_ms     = req_now_ms;
      cmd_in.window     = (req_window_len != 16'd0) ? req_window_len : 16'(DEFAULT_WINDOW);
      cmd_in.hdr_ok     = (req_msg_len >= 8'(HDR_LEN));
      cmd_in.offer_ok   = ({1'b0, req_msg_len} >= 9'(OFFER_MIN));
      cmd_in.confirm_ok = ({1'b0, req_msg_len} >= 9'(CONFIRM_MIN));
      cmd_in.from_self  = (req_sender_id == own_id);
      cmd_in.sender_id  = req_sender_id;
      cmd_in.key_ok     = req_key_ok;
      cmd_in.tag_match  = req_tag_match;
      case (req_type)
         REQ_BEGIN:   cmd_in.op = OP_BEGIN;
         REQ_TICK:    cmd_in.op = OP_TICK;
         REQ_OFFER:   cmd_in.op = has_len ? OP_OFFER : OP_NONE;
         REQ_CONFIRM: cmd_in.op = has_len ? OP_CONFIRM : OP_NONE;
         REQ_ABORT:   cmd_in.op = has_len ? OP_ABORT : OP_NONE;
         default:     cmd_in.op = OP_NONE;
      endcase
   end

   assign req_ready = !valid_ff || cmd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// File: sv/phc_queue.sv
// Short command queue between the front and back stages.
`timescale 1ns / 1ps
module phc_queue #(
   parameter int DEPTH = phc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  phc_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output phc_pkg::cmd_type pop_data
);
   import phc_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            push;
   logic            pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/phc_back.sv
// Back stage: handshake state machine and the registered response.
`timescale 1ns / 1ps
module phc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  phc_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output phc_pkg::rsp_type rsp
);
   import phc_pkg::*;

   hs_state_type state_ff, state_in;
   why_type      reason_ff, reason_in;
   logic [31:0]  deadline_ff, deadline_in;
   logic [63:0]  peer_id_ff, peer_id_in;
   logic         have_peer_ff, have_peer_in;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff, rsp_in;
   logic [31:0]  diff;
   logic         past;
   logic         is_peer;
   logic         active;
   logic         take;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      diff    = cmd.now_ms - deadline_ff;
      past    = (diff != 32'd0) && !diff[31];
      is_peer = (cmd.sender_id == peer_id_ff);
      active  = (state_ff != ST_IDLE) && (state_ff != ST_ABORTED);

      state_in     = state_ff;
      reason_in    = reason_ff;
      deadline_in  = deadline_ff;
      peer_id_in   = peer_id_ff;
      have_peer_in = have_peer_ff;
      rsp_in       = '0;

      case (cmd.op)
         OP_BEGIN: begin
            state_in        = ST_WAITING;
            reason_in       = WHY_NONE;
            deadline_in     = cmd.now_ms + {16'd0, cmd.window};
            peer_id_in      = '0;
            have_peer_in    = 1'b0;
            rsp_in.tx_offer = 1'b1;
         end
         OP_TICK: begin
            if ((state_ff == ST_WAITING || state_ff == ST_CONFIRMING) && past) begin
               reason_in = WHY_TIMEOUT;
            end
         end
         OP_OFFER: begin
            if (active) begin
               if (state_ff == ST_DONE) begin
                  if (!past && cmd.hdr_ok && !is_peer && !cmd.from_self) begin
                     reason_in = WHY_THIRD;
                  end
               end else if (cmd.offer_ok && !cmd.from_self) begin
                  if (have_peer_ff && is_peer) begin
                     rsp_in.tx_confirm = (state_ff == ST_CONFIRMING);
                  end else if (have_peer_ff) begin
                     reason_in = WHY_THIRD;
                  end else begin
                     peer_id_in           = cmd.sender_id;
                     have_peer_in         = 1'b1;
                     rsp_in.peer_accepted = 1'b1;
                     if (!cmd.key_ok) begin
                        reason_in = WHY_BAD_KEY;
                     end else begin
                        state_in          = ST_CONFIRMING;
                        rsp_in.tx_confirm = 1'b1;
                        rsp_in.tx_offer   = 1'b1;
                     end
                  end
               end
            end
         end
         OP_CONFIRM: begin
            if (active && cmd.confirm_ok && have_peer_ff && is_peer) begin
               if (!cmd.tag_match) begin
                  reason_in = WHY_BAD_CONFIRM;
               end else if (state_ff == ST_CONFIRMING) begin
                  state_in         = ST_DONE;
                  rsp_in.completed = 1'b1;
               end
            end
         end
         OP_ABORT: begin
            if (active) begin
               reason_in = WHY_PEER;
            end
         end
         default: begin
         end
      endcase

      // a fresh reason only appears on an abort step
      if (cmd.op != OP_BEGIN && reason_in != reason_ff) begin
         state_in        = ST_ABORTED;
         rsp_in.tx_abort = 1'b1;
         rsp_in.aborted  = 1'b1;
      end

      rsp_in.new_state  = state_in;
      rsp_in.abort_code = reason_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reason_ff    <= WHY_NONE;
         deadline_ff  <= '0;
         peer_id_ff   <= '0;
         have_peer_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff     <= state_in;
            reason_ff    <= reason_in;
            deadline_ff  <= deadline_in;
            peer_id_ff   <= peer_id_in;
            have_peer_ff <= have_peer_in;
         end
         if (cmd_ready) begin
            rsp_valid_ff <= cmd_valid;
         end
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/pairing_handshake_controller.sv
// Pairing handshake controller: top level, own identifier register and checks.
//
// Each request transfer yields exactly one response transfer, in order. A request
// is classified and registered in the front stage, waits in a short queue, and is
// executed by the back stage, which then holds the response in an output register.
// One request per cycle is sustained when nothing stalls; on its way a request
// passes the front register, the queue and the output register. While the
// response side is held, the request side keeps flowing for QUEUE_DEPTH + 1
// further transfers, filling the queue and the front register, before req_ready
// drops. Write csr_wr_data with csr_wr_en only while no transfer is pending.
`timescale 1ns / 1ps
module pairing_handshake_controller #(
   parameter int QUEUE_DEPTH = phc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_window_len,
   input  logic [7:0]  req_msg_len,
   input  logic [63:0] req_sender_id,
   input  logic        req_key_ok,
   input  logic        req_tag_match,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_new_state,
   output logic [2:0]  rsp_abort_code,
   output logic        rsp_tx_offer,
   output logic        rsp_tx_confirm,
   output logic        rsp_tx_abort,
   output logic        rsp_completed,
   output logic        rsp_aborted,
   output logic        rsp_peer_accepted
);
   import phc_pkg::*;

   logic [63:0] own_id_ff;
   logic        front_valid;
   logic        front_ready;
   cmd_type     front_cmd;
   logic        back_valid;
   logic        back_ready;
   cmd_type     back_cmd;
   rsp_type     rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else if (csr_wr_en) begin
         own_id_ff <= csr_wr_data;
      end
   end

   phc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_now_ms     (req_now_ms),
      .req_window_len (req_window_len),
      .req_msg_len    (req_msg_len),
      .req_sender_id  (req_sender_id),
      .req_key_ok     (req_key_ok),
      .req_tag_match  (req_tag_match),
      .own_id         (own_id_ff),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   phc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   phc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_new_state     = rsp.new_state;
   assign rsp_abort_code    = rsp.abort_code;
   assign rsp_tx_offer      = rsp.tx_offer;
   assign rsp_tx_confirm    = rsp.tx_confirm;
   assign rsp_tx_abort      = rsp.tx_abort;
   assign rsp_completed     = rsp.completed;
   assign rsp_aborted       = rsp.aborted;
   assign rsp_peer_accepted = rsp.peer_accepted;

   a_abort_code_only_when_aborted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_new_state == ST_ABORTED) == (rsp_abort_code != WHY_NONE)))
      else $error("abort code and state disagree");

   a_abort_flags_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_aborted == rsp_tx_abort)
                 && (!rsp_aborted || rsp_new_state == ST_ABORTED))
      else $error("abort flags inconsistent");

   a_completed_means_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_completed |-> rsp_new_state == ST_DONE && !rsp_aborted)
      else $error("completion without done state");

   a_accept_with_key_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_peer_accepted |->
         (rsp_new_state == ST_CONFIRMING && rsp_tx_confirm)
         || (rsp_aborted && rsp_abort_code == WHY_BAD_KEY))
      else $error("peer accepted without confirm or bad key abort");

endmodule

// File: tb/sv/pairing_handshake_controller_test.sv
// Self-checking testbench for the pairing handshake controller.
`timescale 1ns / 1ps
module pairing_handshake_controller_test;
   import phc_pkg::*;

   localparam int          HALF_PERIOD  = 6;
   localparam int          RESET_CYCLES = 12;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_LIMIT  = 5000;
   localparam int          SETTLE       = 8;
   localparam int          HOLD_OFF     = 150;
   localparam int          PHASES       = 5;
   localparam int          RANDOM_ITEMS = 1400;

   localparam logic [2:0]  REQ_CODE_MAX = 3'd7;
   localparam logic [63:0] OWN_A        = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] PEER_A       = 64'hFEDC_BA98_7654_3210;
   localparam logic [63:0] THIRD_A      = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [5:0] F_NONE    = 6'b000000;
   localparam logic [5:0] F_OFFER   = 6'b100000;
   localparam logic [5:0] F_CONFIRM = 6'b010000;
   localparam logic [5:0] F_ABORT   = 6'b001000;
   localparam logic [5:0] F_DONE    = 6'b000100;
   localparam logic [5:0] F_ABORTED = 6'b000010;
   localparam logic [5:0] F_PEER    = 6'b000001;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] now;
      logic [15:0] win;
      logic [7:0]  len;
      logic [63:0] sender;
      logic        key_ok;
      logic        tag_match;
   } pair_req_type;

   typedef struct {
      pair_req_type item;
      bit           typed;
      rsp_type      want;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [63:0] csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [31:0] req_now_ms;
   logic [15:0] req_window_len;
   logic [7:0]  req_msg_len;
   logic [63:0] req_sender_id;
   logic        req_key_ok;
   logic        req_tag_match;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_new_state;
   logic [2:0]  rsp_abort_code;
   logic        rsp_tx_offer;
   logic        rsp_tx_confirm;
   logic        rsp_tx_abort;
   logic        rsp_completed;
   logic        rsp_aborted;
   logic        rsp_peer_accepted;

   pairing_handshake_controller dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_now_ms        (req_now_ms),
      .req_window_len    (req_window_len),
      .req_msg_len       (req_msg_len),
      .req_sender_id     (req_sender_id),
      .req_key_ok        (req_key_ok),
      .req_tag_match     (req_tag_match),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_new_state     (rsp_new_state),
      .rsp_abort_code    (rsp_abort_code),
      .rsp_tx_offer      (rsp_tx_offer),
      .rsp_tx_confirm    (rsp_tx_confirm),
      .rsp_tx_abort      (rsp_tx_abort),
      .rsp_completed     (rsp_completed),
      .rsp_aborted       (rsp_aborted),
      .rsp_peer_accepted (rsp_peer_accepted)
   );

   always #HALF_PERIOD clock = ~clock;

   // predicted handshake state
   logic [63:0]  pair_own_id  = '0;
   hs_state_type hs_state     = ST_IDLE;
   why_type      hs_why       = WHY_NONE;
   logic [31:0]  hs_start     = '0;
   logic [15:0]  hs_window    = '0;
   logic [63:0]  hs_peer      = '0;
   logic         hs_have_peer = 1'b0;
   logic         hs_confirmed = 1'b0;
   rsp_type      step_out;

   rsp_type       expected_outcomes[$];
   table_row_type stim_table[$];

   int          errors = 0;
   int          requests_sent = 0;
   int          meaningful = 0;
   int          responses_checked = 0;
   int          completions = 0;
   int          aborts = 0;
   int          id_settings = 0;
   int unsigned cycle_count = 0;
   bit          steady = 1'b0;
   bit          hold_off_pending = 1'b0;

   function automatic logic window_passed(logic [31:0] now);
      logic [31:0] d;
      d = now - (hs_start + 32'(hs_window));
      return (d != 32'd0) && !d[31];
   endfunction

   function automatic void go_abort(why_type why);
      if (hs_state != ST_ABORTED) begin
         hs_state = ST_ABORTED;
         hs_why = why;
         step_out.tx_abort = 1'b1;
         step_out.aborted = 1'b1;
      end
   endfunction

   function automatic rsp_type advance_handshake(pair_req_type it);
      step_out = '0;
      case (it.kind)
         REQ_BEGIN: begin
            hs_state = ST_WAITING;
            hs_why = WHY_NONE;
            hs_start = it.now;
            hs_window = (it.win != 16'd0) ? it.win : 16'(DEFAULT_WINDOW);
            hs_peer = '0;
            hs_have_peer = 1'b0;
            hs_confirmed = 1'b0;
            step_out.tx_offer = 1'b1;
         end
         REQ_TICK: begin
            if ((hs_state == ST_WAITING || hs_state == ST_CONFIRMING) &&
                window_passed(it.now))
               go_abort(WHY_TIMEOUT);
         end
         REQ_OFFER, REQ_CONFIRM, REQ_ABORT: begin
            if (it.len != 8'd0 && hs_state != ST_IDLE && hs_state != ST_ABORTED) begin
               if (it.kind == REQ_OFFER) begin
                  if (hs_state == ST_DONE) begin
                     if (!window_passed(it.now) && 32'(it.len) >= HDR_LEN &&
                         it.sender != hs_peer && it.sender != pair_own_id)
                        go_abort(WHY_THIRD);
                  end else if (32'(it.len) >= OFFER_MIN && it.sender != pair_own_id) begin
                     if (hs_have_peer && it.sender == hs_peer) begin
                        if (hs_state == ST_CONFIRMING)
                           step_out.tx_confirm = 1'b1;
                     end else if (hs_have_peer) begin
                        go_abort(WHY_THIRD);
                     end else begin
                        hs_peer = it.sender;
                        hs_have_peer = 1'b1;
                        step_out.peer_accepted = 1'b1;
                        if (!it.key_ok) begin
                           go_abort(WHY_BAD_KEY);
                        end else begin
                           hs_state = ST_CONFIRMING;
                           step_out.tx_confirm = 1'b1;
                           step_out.tx_offer = 1'b1;
                        end
                     end
                  end
               end else if (it.kind == REQ_CONFIRM) begin
                  if (32'(it.len) >= CONFIRM_MIN && hs_have_peer && it.sender == hs_peer) begin
                     if (!it.tag_match) begin
                        go_abort(WHY_BAD_CONFIRM);
                     end else begin
                        hs_confirmed = 1'b1;
                        if (hs_state == ST_CONFIRMING) begin
                           hs_state = ST_DONE;
                           step_out.completed = 1'b1;
                        end
                     end
                  end
               end else begin
                  go_abort(WHY_PEER);
               end
            end
         end
         default: ;
      endcase
      step_out.new_state = hs_state;
      step_out.abort_code = hs_why;
      return step_out;
   endfunction

   function automatic pair_req_type make_req(logic [2:0] kind, logic [31:0] now,
                                             logic [15:0] win, logic [7:0] len,
                                             logic [63:0] sender, logic key_ok,
                                             logic tag_match);
      pair_req_type it;
      it.kind = kind;
      it.now = now;
      it.win = win;
      it.len = len;
      it.sender = sender;
      it.key_ok = key_ok;
      it.tag_match = tag_match;
      return it;
   endfunction

   function automatic rsp_type outcome(hs_state_type s, why_type w, logic [5:0] f);
      rsp_type r;
      r.new_state = s;
      r.abort_code = w;
      {r.tx_offer, r.tx_confirm, r.tx_abort, r.completed, r.aborted,
       r.peer_accepted} = f;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic logic [7:0] pick_len(int floor);
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(0, floor - 1));
         1: return 8'(floor);
         default: return 8'($urandom_range(floor, 255));
      endcase
   endfunction

   function automatic logic [31:0] pick_time(logic [31:0] t0, int unsigned span);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return t0 + 32'($urandom_range(0, span));
         6, 7: return t0 + 32'(span) + 32'($urandom_range(0, 3)) - 32'd1;
         8: return t0 + 32'(span) + 32'($urandom_range(2, 200000));
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic pair_req_type noise_req();
      return make_req(3'($urandom_range(0, REQ_CODE_MAX)), 32'($urandom),
                      16'($urandom), 8'($urandom), {32'($urandom), 32'($urandom)},
                      1'($urandom), 1'($urandom));
   endfunction

   function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic add_row(pair_req_type it, bit typed, rsp_type want);
      table_row_type row;
      row.item = it;
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endtask

   task automatic send(pair_req_type it, bit typed, rsp_type typed_want);
      int           gap;
      hs_state_type was;
      rsp_type      want;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= it.kind;
      req_now_ms     <= it.now;
      req_window_len <= it.win;
      req_msg_len    <= it.len;
      req_sender_id  <= it.sender;
      req_key_ok     <= it.key_ok;
      req_tag_match  <= it.tag_match;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      was = hs_state;
      want = advance_handshake(it);
      if (want.new_state != was || want[5:0] != F_NONE) meaningful++;
      if (want.completed) completions++;
      if (want.aborted) aborts++;
      if (typed) want = typed_want;
      expected_outcomes.push_back(want);
      requests_sent++;
   endtask

   task automatic drain();
      int w;
      req_valid <= 1'b0;
      for (w = 0; w < DRAIN_LIMIT && expected_outcomes.size() != 0; w++)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_own_id(logic [63:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pair_own_id = value;
      id_settings++;
   endtask

   task automatic run_exchange(bit flat_out);
      logic [31:0] t0;
      logic [15:0] win;
      int unsigned span;
      logic [63:0] peer;
      int          extras;
      steady = flat_out || ($urandom_range(0, 7) == 0);
      t0 = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 40000))
                                       : 32'($urandom);
      case ($urandom_range(0, 9))
         0: win = '0;
         1: win = '1;
         2, 3, 4, 5: win = 16'($urandom_range(1, 200));
         default: win = 16'($urandom_range(1, 65535));
      endcase
      span = (win == 16'd0) ? DEFAULT_WINDOW : 32'(win);
      peer = ($urandom_range(0, 19) == 0) ? pair_own_id : {32'($urandom), 32'($urandom)};
      if ($urandom_range(0, 4) == 0) send(noise_req(), 1'b0, '0);
      send(make_req(REQ_BEGIN, t0, win, 8'($urandom), {32'($urandom), 32'($urandom)},
                    1'($urandom), 1'($urandom)), 1'b0, '0);
      if ($urandom_range(0, 9) < 8)
         send(make_req(REQ_OFFER, pick_time(t0, span), 16'($urandom), pick_len(OFFER_MIN),
                       peer, $urandom_range(0, 15) != 0, 1'($urandom)), 1'b0, '0);
      if ($urandom_range(0, 3) == 0)
         send(make_req(REQ_TICK, pick_time(t0, span), 16'($urandom), 8'($urandom),
                       {32'($urandom), 32'($urandom)}, 1'($urandom), 1'($urandom)), 1'b0, '0);
      if ($urandom_range(0, 9) < 8)
         send(make_req(REQ_CONFIRM, pick_time(t0, span), 16'($urandom), pick_len(CONFIRM_MIN),
                       peer, 1'($urandom), $urandom_range(0, 9) != 0), 1'b0, '0);
      extras = int'($urandom_range(0, 5));
      repeat (extras) begin
         case ($urandom_range(0, 9))
            0, 1: send(make_req(REQ_OFFER, pick_time(t0, span), 16'($urandom),
                                pick_len(OFFER_MIN), peer, 1'($urandom), 1'($urandom)),
                       1'b0, '0);
            2, 3: send(make_req(REQ_OFFER, pick_time(t0, span), 16'($urandom),
                                pick_len(OFFER_MIN), {32'($urandom), 32'($urandom)},
                                1'($urandom), 1'($urandom)), 1'b0, '0);
            4: send(make_req(REQ_OFFER, pick_time(t0, span), 16'($urandom),
                             pick_len(OFFER_MIN), pair_own_id, 1'($urandom), 1'($urandom)),
                    1'b0, '0);
            5, 6: send(make_req(REQ_TICK, pick_time(t0, span), 16'($urandom), 8'($urandom),
                                {32'($urandom), 32'($urandom)}, 1'($urandom), 1'($urandom)),
                       1'b0, '0);
            7: send(make_req(REQ_CONFIRM, pick_time(t0, span), 16'($urandom),
                             pick_len(CONFIRM_MIN), peer, 1'($urandom), 1'($urandom)),
                    1'b0, '0);
            8: send(make_req(REQ_ABORT, pick_time(t0, span), 16'($urandom), 8'($urandom),
                             {32'($urandom), 32'($urandom)}, 1'($urandom), 1'($urandom)),
                    1'b0, '0);
            default: send(noise_req(), 1'b0, '0);
         endcase
      end
   endtask

   // response side: random stalls, steady stretches and one long hold-off
   initial begin
      int hold_left;
      int stall_left;
      hold_left = 0;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left = HOLD_OFF;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("response transfer with no outstanding request");
            errors++;
         end else begin
            want = expected_outcomes.pop_front();
            check_field("new_state", want.new_state, rsp_new_state);
            check_field("abort_code", want.abort_code, rsp_abort_code);
            check_field("tx_offer", 3'(want.tx_offer), 3'(rsp_tx_offer));
            check_field("tx_confirm", 3'(want.tx_confirm), 3'(rsp_tx_confirm));
            check_field("tx_abort", 3'(want.tx_abort), 3'(rsp_tx_abort));
            check_field("completed", 3'(want.completed), 3'(rsp_completed));
            check_field("aborted", 3'(want.aborted), 3'(rsp_aborted));
            check_field("peer_accepted", 3'(want.peer_accepted), 3'(rsp_peer_accepted));
            responses_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int directed;
      int phase;
      int random_base;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_valid      <= 1'b0;
      req_type       <= REQ_BEGIN;
      req_now_ms     <= '0;
      req_window_len <= '0;
      req_msg_len    <= '0;
      req_sender_id  <= '0;
      req_key_ok     <= 1'b0;
      req_tag_match  <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_own_id(OWN_A);

      add_row(make_req(REQ_OFFER, 32'h0, 16'h0, 8'd255, PEER_A, 1'b1, 1'b1),
              1'b1, outcome(ST_IDLE, WHY_NONE, F_NONE));
      add_row(make_req(REQ_TICK, 32'hFFFF_FFFF, 16'hFFFF, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b1, outcome(ST_IDLE, WHY_NONE, F_NONE));
      add_row(make_req(REQ_CODE_MAX, 32'h1234_5678, 16'h5A5A, 8'd60, PEER_A, 1'b1, 1'b1),
              1'b1, outcome(ST_IDLE, WHY_NONE, F_NONE));
      add_row(make_req(REQ_BEGIN, 32'hFFFF_FF00, 16'h0, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b1, outcome(ST_WAITING, WHY_NONE, F_OFFER));
      add_row(make_req(REQ_OFFER, 32'hFFFF_FF10, 16'h0, 8'd0, PEER_A, 1'b1, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_OFFER, 32'hFFFF_FF20, 16'h0, 8'(OFFER_MIN - 1), PEER_A, 1'b1, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_OFFER, 32'hFFFF_FF30, 16'h0, 8'(OFFER_MIN), OWN_A, 1'b1, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_TICK, 32'h0000_7430, 16'h0, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_OFFER, 32'hFFFF_FF40, 16'h0, 8'(OFFER_MIN), PEER_A, 1'b1, 1'b0),
              1'b1, outcome(ST_CONFIRMING, WHY_NONE, F_OFFER | F_CONFIRM | F_PEER));
      add_row(make_req(REQ_OFFER, 32'hFFFF_FF50, 16'h0, 8'd255, PEER_A, 1'b1, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_CONFIRM, 32'hFFFF_FF60, 16'h0, 8'(CONFIRM_MIN - 1), PEER_A,
                       1'b0, 1'b1), 1'b0, '0);
      add_row(make_req(REQ_CONFIRM, 32'hFFFF_FF70, 16'h0, 8'(CONFIRM_MIN), THIRD_A,
                       1'b0, 1'b1), 1'b0, '0);
      add_row(make_req(REQ_CONFIRM, 32'hFFFF_FF80, 16'h0, 8'(CONFIRM_MIN), PEER_A,
                       1'b0, 1'b1), 1'b1, outcome(ST_DONE, WHY_NONE, F_DONE));
      add_row(make_req(REQ_OFFER, 32'h0000_7430, 16'h0, 8'(HDR_LEN), THIRD_A, 1'b1, 1'b0),
              1'b1, outcome(ST_ABORTED, WHY_THIRD, F_ABORT | F_ABORTED));
      add_row(make_req(REQ_ABORT, 32'h0000_7500, 16'h0, 8'd1, 64'h0, 1'b0, 1'b0),
              1'b1, outcome(ST_ABORTED, WHY_THIRD, F_NONE));
      add_row(make_req(REQ_BEGIN, 32'h0000_1000, 16'hFFFF, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b1, outcome(ST_WAITING, WHY_NONE, F_OFFER));
      add_row(make_req(REQ_OFFER, 32'h0000_1001, 16'h0, 8'd200, PEER_A, 1'b0, 1'b0),
              1'b1, outcome(ST_ABORTED, WHY_BAD_KEY, F_ABORT | F_ABORTED | F_PEER));
      add_row(make_req(REQ_BEGIN, 32'h0000_2000, 16'h1, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b1, outcome(ST_WAITING, WHY_NONE, F_OFFER));
      add_row(make_req(REQ_TICK, 32'h0000_2001, 16'h0, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_TICK, 32'h0000_2002, 16'h0, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b1, outcome(ST_ABORTED, WHY_TIMEOUT, F_ABORT | F_ABORTED));
      add_row(make_req(REQ_BEGIN, 32'h0, 16'd100, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b1, outcome(ST_WAITING, WHY_NONE, F_OFFER));
      add_row(make_req(REQ_OFFER, 32'd10, 16'h0, 8'(OFFER_MIN), PEER_A, 1'b1, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_OFFER, 32'd20, 16'h0, 8'(OFFER_MIN), THIRD_A, 1'b1, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_BEGIN, 32'h0, 16'd100, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_ABORT, 32'd5, 16'h0, 8'd255, 64'h0, 1'b0, 1'b0),
              1'b1, outcome(ST_ABORTED, WHY_PEER, F_ABORT | F_ABORTED));
      add_row(make_req(REQ_BEGIN, 32'h8000_0000, 16'd100, 8'd0, 64'h0, 1'b0, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_OFFER, 32'h8000_0001, 16'h0, 8'd255, PEER_A, 1'b1, 1'b0),
              1'b0, '0);
      add_row(make_req(REQ_CONFIRM, 32'h8000_0002, 16'h0, 8'd255, PEER_A, 1'b1, 1'b0),
              1'b1, outcome(ST_ABORTED, WHY_BAD_CONFIRM, F_ABORT | F_ABORTED));

      foreach (stim_table[i])
         send(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
      directed = stim_table.size();
      drain();

      meaningful = 0;
      random_base = requests_sent;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_own_id('0);
            1: write_own_id('1);
            2: write_own_id(OWN_A);
            default: write_own_id({32'($urandom), 32'($urandom)});
         endcase
         if (phase == 1) begin
            // hold the response side and keep offering so the input stalls
            hold_off_pending = 1'b1;
            repeat (4) run_exchange(1'b1);
         end
         while (requests_sent - random_base < (phase + 1) * RANDOM_ITEMS / PHASES)
            run_exchange(1'b0);
         steady = 1'b0;
         drain();
      end

      if (expected_outcomes.size() != 0) begin
         $error("%0d responses never arrived", expected_outcomes.size());
         errors++;
      end
      $display("Run covered %0d requests (%0d from the directed table) under %0d own-id values.",
               requests_sent, directed, id_settings);
      $display("Checked %0d responses, %0d random ones moving state, %0d completed, %0d aborted.",
               responses_checked, meaningful, completions, aborts);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
sv/phc_pkg.sv
sv/phc_front.sv
sv/phc_queue.sv
sv/phc_back.sv
sv/pairing_handshake_controller.sv
tb/sv/pairing_handshake_controller_test.sv
